[rtl/core/kfm_pkg.sv]
// ----------------------------------------------------------------------------
// kfm_pkg: shared types and constants for the key frequency min/max table
// Table size, field widths, action codes and the command/result words.
// ----------------------------------------------------------------------------
package kfm_pkg;

  localparam int KEY_COUNT  = 256;
  localparam int ADDR_BITS  = $clog2(KEY_COUNT);
  localparam int COUNT_BITS = 16;
  localparam int STAMP_BITS = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // action codes
  localparam logic [1:0] ACT_INC  = 2'd0;
  localparam logic [1:0] ACT_DEC  = 2'd1;
  localparam logic [1:0] ACT_QMAX = 2'd2;
  localparam logic [1:0] ACT_QMIN = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key_id;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_key;
    logic       empty_flag;
  } out_word_t;

  // one table entry: count plus stamp of its last change
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

endpackage

[rtl/core/kfm_ram.sv]
// ----------------------------------------------------------------------------
// kfm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module kfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/kfm_cmp.sv]
// ----------------------------------------------------------------------------
// kfm_cmp: entry compare unit
// Decides whether a candidate entry beats the current best entry.
// ----------------------------------------------------------------------------
module kfm_cmp (
  input  kfm_pkg::entry_t cand,
  input  kfm_pkg::entry_t best,
  input  logic            want_max,
  output logic            better
);

  always_comb begin
    if (cand.count == best.count) begin
      // tie: earlier stamp wins, the current best keeps a full tie
      better = cand.stamp < best.stamp;
    end else if (want_max) begin
      better = cand.count > best.count;
    end else begin
      better = cand.count < best.count;
    end
  end

endmodule

[rtl/core/key_frequency_min_max_table.sv]
// ----------------------------------------------------------------------------
// key_frequency_min_max_table: per-key counters with max/min key query
// Sequencer around one entry RAM and one shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (action, key_id) is taken at a rising edge with start high
//   and busy low. busy stays high until the command is finished.
//   Increment / decrement: read-modify-write of one entry; busy stays high
//   through the read state (S_RD) and the modify state (S_MOD). No result word.
//   Max / min query: the sequencer reads all 256 entries, one per cycle, from
//   the single RAM read port and feeds each to the compare unit. The result
//   word is on result with done high for exactly one cycle, in the reply state
//   (S_REPLY) that follows the scan and the drain state (S_DRAIN); the next
//   command can be taken in the cycle after done.
//   The receiver cannot stall: done is a strobe and must be sampled at once.
//   Reset (rst, synchronous) clears every entry's valid bit, so all counts
//   read as zero, and zeroes the update stamp. Stamps are not cleared; a
//   stamp is only used for a key with a nonzero count.
//   An empty table answers result_key 0 with empty_flag 1.
// ----------------------------------------------------------------------------
module key_frequency_min_max_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  kfm_pkg::in_word_t   cmd,
  output logic                done,
  output kfm_pkg::out_word_t  result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_REPLY = 3'd5;

  localparam logic [kfm_pkg::ADDR_BITS-1:0] LAST_ADDR =
    kfm_pkg::ADDR_BITS'(kfm_pkg::KEY_COUNT - 1);

  logic [2:0]                         state;
  kfm_pkg::in_word_t                  cmd_q;
  logic [kfm_pkg::ADDR_BITS-1:0]      addr;
  logic [kfm_pkg::ADDR_BITS-1:0]      rd_idx;
  logic                               rd_live;
  logic                               vld_q;
  logic [kfm_pkg::KEY_COUNT-1:0]      valid;
  logic [kfm_pkg::STAMP_BITS-1:0]     seq;
  kfm_pkg::entry_t                    best;
  logic [kfm_pkg::ADDR_BITS-1:0]      best_idx;
  logic                               any;

  logic [kfm_pkg::ADDR_BITS-1:0]      rd_addr;
  logic [kfm_pkg::ADDR_BITS-1:0]      key_addr;
  kfm_pkg::entry_t                    rd_data;
  kfm_pkg::entry_t                    cand;
  kfm_pkg::entry_t                    wr_data;
  logic                               wr_en;
  logic                               in_range;
  logic                               is_inc;
  logic                               better;

  assign key_addr = cmd_q.key_id[kfm_pkg::ADDR_BITS-1:0];
  assign in_range = {1'b0, cmd_q.key_id} < 9'(kfm_pkg::KEY_COUNT);
  assign is_inc   = cmd_q.action == kfm_pkg::ACT_INC;
  assign rd_addr  = (state == S_SCAN) ? addr : key_addr;

  // entry as seen in the cycle after the read: invalid entries count zero
  always_comb begin
    cand.stamp = rd_data.stamp;
    cand.count = vld_q ? rd_data.count : '0;
  end

  // write back on a count change; decrement to zero only drops the valid bit
  always_comb begin
    wr_data.stamp = seq;
    wr_data.count = is_inc ? cand.count + 1'b1 : cand.count - 1'b1;
    wr_en = 1'b0;
    if (state == S_MOD && in_range) begin
      if (is_inc) begin
        wr_en = cand.count != kfm_pkg::COUNT_MAX;
      end else begin
        wr_en = cand.count > kfm_pkg::COUNT_BITS'(1);
      end
    end
  end

  kfm_ram #(
    .WIDTH ($bits(kfm_pkg::entry_t)),
    .DEPTH (kfm_pkg::KEY_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (key_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kfm_cmp u_cmp (
    .cand     (cand),
    .best     (best),
    .want_max (cmd_q.action == kfm_pkg::ACT_QMAX),
    .better   (better)
  );

  // valid bit follows the read pipeline; scan tag marks live read data
  always_ff @(posedge clk) begin
    vld_q   <= valid[rd_addr];
    rd_idx  <= addr;
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= state == S_SCAN;
    end
  end

  // running best during a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (state == S_IDLE) begin
      any <= 1'b0;
    end else if (rd_live && cand.count != '0 && (!any || better)) begin
      any      <= 1'b1;
      best     <= cand;
      best_idx <= rd_idx;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      seq   <= '0;
      addr  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          addr <= '0;
          if (start) begin
            cmd_q <= cmd;
            if (cmd.action == kfm_pkg::ACT_QMAX || cmd.action == kfm_pkg::ACT_QMIN) begin
              state <= S_SCAN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (wr_en) begin
            valid[key_addr] <= 1'b1;
            seq             <= seq + 1'b1;
          end else if (in_range && !is_inc && cand.count == kfm_pkg::COUNT_BITS'(1)) begin
            valid[key_addr] <= 1'b0;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          addr <= addr + 1'b1;
          if (addr == LAST_ADDR) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_REPLY;
        end
        S_REPLY: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_REPLY;

  always_comb begin
    result.empty_flag = !any;
    result.result_key = any ? 8'(best_idx) : 8'd0;
  end

endmodule

[bench/kfm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfm_checker: prediction and compare for the key frequency min/max table
// Watches the command and result channels, keeps its own count/stamp table,
// queues the expected answer of every accepted query and checks each result.
// ----------------------------------------------------------------------------
module kfm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  kfm_pkg::in_word_t  cmd,
  input  logic               done,
  input  kfm_pkg::out_word_t result,
  output int                 errors,
  output int                 pending,
  output int                 answers,
  output int                 empties
);
  import kfm_pkg::*;

  logic [COUNT_BITS-1:0] count_tbl [KEY_COUNT];
  logic [STAMP_BITS-1:0] stamp_tbl [KEY_COUNT];
  logic [STAMP_BITS-1:0] next_stamp;
  out_word_t             answer_q [$];
  out_word_t             want;

  initial begin
    errors  = 0;
    pending = 0;
    answers = 0;
    empties = 0;
  end

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("MISMATCH at %0t ns: %s, expected %0d, got %0d", $time, what, exp_v, got_v);
    errors++;
  endtask

  // count change of one key; the stamp moves only when the count stays nonzero
  task automatic apply_update(input in_word_t w);
    logic [COUNT_BITS-1:0] c;
    c = count_tbl[w.key_id];
    if (int'(w.key_id) < KEY_COUNT) begin
      if (w.action == ACT_INC) begin
        if (c != COUNT_MAX) begin
          count_tbl[w.key_id] = c + 1'b1;
          stamp_tbl[w.key_id] = next_stamp;
          next_stamp++;
        end
      end else if (c != '0) begin
        count_tbl[w.key_id] = c - 1'b1;
        if (c != 1) begin
          stamp_tbl[w.key_id] = next_stamp;
          next_stamp++;
        end
      end
    end
  endtask

  // full scan; equal counts go to the older stamp, then to the lower key
  function automatic out_word_t scan_answer(input logic want_max);
    out_word_t a;
    logic      found;
    logic      better;
    int        best;
    found = 1'b0;
    best  = 0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (count_tbl[k] != '0) begin
        if (!found) begin
          found = 1'b1;
          best  = k;
        end else begin
          if (count_tbl[k] == count_tbl[best])
            better = stamp_tbl[k] < stamp_tbl[best];
          else if (want_max)
            better = count_tbl[k] > count_tbl[best];
          else
            better = count_tbl[k] < count_tbl[best];
          if (better) best = k;
        end
      end
    end
    a.result_key = found ? 8'(best) : 8'd0;
    a.empty_flag = !found;
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEY_COUNT; k++) count_tbl[k] = '0;
      next_stamp = '0;
      answer_q.delete();
    end else begin
      if (done === 1'b1) begin
        if (answer_q.size() == 0) begin
          report("result word with no query waiting", -1, int'(result.result_key));
        end else begin
          want = answer_q.pop_front();
          answers++;
          if (want.empty_flag) empties++;
          if (result.result_key !== want.result_key)
            report("result_key", int'(want.result_key), int'(result.result_key));
          if (result.empty_flag !== want.empty_flag)
            report("empty_flag", int'(want.empty_flag), int'(result.empty_flag));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (cmd.action == ACT_QMAX || cmd.action == ACT_QMIN)
          answer_q.push_back(scan_answer(cmd.action == ACT_QMAX));
        else
          apply_update(cmd);
      end
    end
    pending = answer_q.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the key frequency min/max table
// Directed corner words, then random update/query traffic around small key
// pools with random gaps, then a gap-free run that climbs and drains one key.
// ----------------------------------------------------------------------------
module tb;
  import kfm_pkg::*;

  // longest correct stretch without a handshake is one query scan plus a
  // sender gap; the watchdog limit is set above that
  localparam int WATCHDOG_LIMIT = 3000;
  // after the last answer, long enough for one more full scan to show up
  localparam int DRAIN_CYCLES   = 300;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  in_word_t  cmd;
  out_word_t result;

  int errors;
  int pending;
  int answers;
  int empties;
  int idle_run;
  int words_sent;
  bit gaps_on;

  key_frequency_min_max_table dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  kfm_checker table_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending),
    .answers (answers),
    .empties (empties)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: cycles in a row with neither a command nor a result word taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("Watchdog: %0d cycles without a handshake", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // present one command word at the falling edge, hold it until taken
  task automatic send_word(input logic [1:0] act, input logic [7:0] key);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= {act, key};
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // drop start and hold it low; n gives the length of the gap
  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // random burst of idling, only while gaps are enabled
  task automatic maybe_pause();
    if (gaps_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 18));
  endtask

  initial begin
    logic [7:0] key_pool [8];
    logic [7:0] key;
    logic [7:0] hot_key;
    logic [1:0] act;
    int         roll;
    int         inc_weight;
    int         hot_incs;

    words_sent = 0;
    gaps_on    = 1'b1;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // -- directed part --
    // empty table answers key 0 with the empty flag
    send_word(ACT_QMAX, 8'hFF);
    send_word(ACT_QMIN, 8'h00);
    // equal counts: the older stamp (key 0) wins both ways
    send_word(ACT_INC, 8'h00);
    send_word(ACT_INC, 8'hFF);
    send_word(ACT_QMAX, 8'h5A);
    send_word(ACT_QMIN, 8'hA5);
    // key 255 pulls ahead
    send_word(ACT_INC, 8'hFF);
    send_word(ACT_QMAX, 8'h00);
    send_word(ACT_QMIN, 8'hFF);
    // key 0 leaves the table, then a decrement of the absent key is ignored
    send_word(ACT_DEC, 8'h00);
    send_word(ACT_QMIN, 8'h00);
    send_word(ACT_DEC, 8'h00);
    send_word(ACT_QMAX, 8'h00);
    // alternating bit patterns; decrement to a nonzero count restamps 255
    send_word(ACT_INC, 8'hAA);
    send_word(ACT_INC, 8'h55);
    send_word(ACT_QMIN, 8'h33);
    send_word(ACT_DEC, 8'hFF);
    send_word(ACT_QMAX, 8'hCC);
    send_word(ACT_QMIN, 8'hCC);
    // drain everything back to empty
    send_word(ACT_DEC, 8'hFF);
    send_word(ACT_DEC, 8'hAA);
    send_word(ACT_DEC, 8'h55);
    send_word(ACT_QMAX, 8'h0F);
    send_word(ACT_QMIN, 8'hF0);

    // -- random part: 10 chunks of 40 words --
    // each chunk has its own key pool and increment bias, so the table
    // fills, ties up and drains; every fourth chunk runs without gaps
    for (int chunk = 0; chunk < 10; chunk++) begin
      for (int p = 0; p < 8; p++) key_pool[p] = 8'($urandom_range(0, 255));
      inc_weight = $urandom_range(25, 70);
      gaps_on    = (chunk % 4) != 3;
      for (int n = 0; n < 40; n++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, 7)];
        else key = 8'($urandom_range(0, 255));
        if (roll < 30) act = ($urandom_range(0, 1) != 0) ? ACT_QMAX : ACT_QMIN;
        else if (roll < 30 + inc_weight * 70 / 100) act = ACT_INC;
        else act = ACT_DEC;
        send_word(act, key);
        maybe_pause();
      end
    end

    // -- closing run, no gaps from here on --
    // one key is incremented hot_incs times, then decremented once more than that
    gaps_on  = 1'b0;
    hot_key  = key_pool[$urandom_range(0, 7)];
    hot_incs = 6;
    repeat (hot_incs) send_word(ACT_INC, hot_key);
    send_word(ACT_QMAX, 8'h00);
    send_word(ACT_QMIN, 8'hFF);
    repeat (hot_incs) send_word(ACT_DEC, hot_key);
    send_word(ACT_DEC, hot_key);
    send_word(ACT_QMAX, 8'h00);
    send_word(ACT_QMIN, 8'h00);

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d command words; %0d query answers checked, %0d on an empty table.",
             words_sent, answers, empties);
    $display("Final gap-free phase moved key %0d up by %0d and back down past zero.",
             hot_key, hot_incs);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/kfm_pkg.sv
rtl/core/kfm_ram.sv
rtl/core/kfm_cmp.sv
rtl/core/key_frequency_min_max_table.sv
bench/kfm_checker.sv
bench/tb.sv
